// ===== design/rfa_pkg.sv =====
// rfa_pkg: widths, limits and the cosine table entry function for the
// rastrigin fitness accumulator. No dependencies.
package rfa_pkg;

  localparam int unsigned X_W             = 28;
  localparam int unsigned FIT_W           = 47;
  localparam int unsigned IDX_W           = 5;
  localparam int unsigned DIM_W           = 11;
  localparam int unsigned COUNT_W         = 10;
  localparam int unsigned COS_W           = 21;
  localparam int unsigned SQ_W            = 2 * X_W;
  localparam int unsigned TERM_W          = 41;
  localparam int unsigned POP_SIZE        = 32;
  localparam int unsigned COS_TABLE_DEPTH = 1024;

  localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(1024);
  localparam logic [FIT_W-1:0] SUM_MAX = {FIT_W{1'b1}};

  typedef struct packed {
    logic              valid;
    logic [TERM_W-1:0] value;
  } term_t;

  // 10 - 10*cos(phase) in Q.16, phase in quarter turns Q30
  function automatic logic [COS_W-1:0] cos_ofs_f(logic [63:0] ph);
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] v;
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] c;
    logic [63:0] m;
    logic [63:0] e;
    logic [63:0] one;
    logic [63:0] res;
    one = 64'd1073741824;
    q   = (ph >> 30) & 64'd3;
    r   = ph & (one - 64'd1);
    v   = q[0] ? (one - r) : r;
    t   = (v * 64'd1686629713) >> 30;
    t2  = (t * t) >> 30;
    c   = one;
    c   = one - ((t2 * c) >> 30) / 64'd132;
    c   = one - ((t2 * c) >> 30) / 64'd90;
    c   = one - ((t2 * c) >> 30) / 64'd56;
    c   = one - ((t2 * c) >> 30) / 64'd30;
    c   = one - ((t2 * c) >> 30) / 64'd12;
    m   = ((t2 * c) >> 30) / 64'd2;
    c   = (m > one) ? 64'd0 : (one - m);
    e   = (64'd10 * c + 64'd8192) >> 14;
    res = (q == 64'd1 || q == 64'd2) ? (64'd655360 + e) : (64'd655360 - e);
    return res[COS_W-1:0];
  endfunction

endpackage

// ===== design/rfa_if.sv =====
// rfa_coord_if and rfa_fit_if: valid/ready channels for coordinate requests
// and fitness results. Depends on rfa_pkg.
interface rfa_coord_if
  import rfa_pkg::*;
;
  logic                   valid;
  logic                   ready;
  logic signed [X_W-1:0]  x_coord;

  modport source (output valid, output x_coord, input ready);
  modport sink   (input valid, input x_coord, output ready);
endinterface

interface rfa_fit_if
  import rfa_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [FIT_W-1:0]  fitness;
  logic [IDX_W-1:0]  vector_index;

  modport source (output valid, output fitness, output vector_index, input ready);
  modport sink   (input valid, input fitness, input vector_index, output ready);
endinterface

// ===== design/rfa_cos_rom.sv =====
// rfa_cos_rom: constant table of 10 - 10*cos over one period, registered
// read. Depends on rfa_pkg.
module rfa_cos_rom
  import rfa_pkg::*;
#(
  parameter int unsigned CosTableDepth = COS_TABLE_DEPTH,
  localparam int unsigned IdxW = $clog2(CosTableDepth)
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [IdxW-1:0]  addr_i,
  output logic [COS_W-1:0] data_o
);

  logic [COS_W-1:0] rom_w [CosTableDepth];
  logic [COS_W-1:0] data_q;

  for (genvar g = 0; g < CosTableDepth; g++) begin : g_entry
    localparam logic [63:0] Ph = (64'(g) << 32) / CosTableDepth;
    assign rom_w[g] = cos_ofs_f(Ph);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= rom_w[addr_i];
    end
  end

  assign data_o = data_q;

endmodule

// ===== design/rfa_term_pipe.sv =====
// rfa_term_pipe: three-stage pipeline forming one rastrigin term per request
// (magnitude and table index, square and table lookup, sum). Depends on rfa_pkg, rfa_if, rfa_cos_rom.
module rfa_term_pipe
  import rfa_pkg::*;
#(
  parameter int unsigned CosTableDepth = COS_TABLE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  rfa_coord_if.sink          coord_if,
  output term_t              term_o
);

  localparam int unsigned IdxW  = $clog2(CosTableDepth);
  localparam int unsigned ProdW = 16 + 17;

  logic              a_v_q, b_v_q, c_v_q;
  logic [X_W-1:0]    raw_w;
  logic [X_W-1:0]    mag_d, mag_q;
  logic [ProdW-1:0]  prod_w;
  logic [IdxW-1:0]   idx_q;
  logic [SQ_W-1:0]   sq_q;
  logic [SQ_W-1:0]   sq_rnd_w;
  logic [COS_W-1:0]  cos_w;
  logic [TERM_W-1:0] term_d, term_q;

  assign coord_if.ready = adv_i;

  assign raw_w  = coord_if.x_coord;
  assign mag_d  = raw_w[X_W-1] ? (X_W'(0) - raw_w) : raw_w;
  assign prod_w = ProdW'(raw_w[15:0]) * ProdW'(CosTableDepth);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
    end else if (adv_i) begin
      a_v_q <= coord_if.valid;
      b_v_q <= a_v_q;
      c_v_q <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      if (coord_if.valid) begin
        mag_q <= mag_d;
        idx_q <= prod_w[16 +: IdxW];
      end
      sq_q   <= SQ_W'(mag_q) * SQ_W'(mag_q);
      term_q <= term_d;
    end
  end

  rfa_cos_rom #(
    .CosTableDepth(CosTableDepth)
  ) u_cos_rom (
    .clk_i (clk_i),
    .en_i  (adv_i),
    .addr_i(idx_q),
    .data_o(cos_w)
  );

  // round the Q.32 square to Q.16 and add the cosine offset
  assign sq_rnd_w = sq_q + SQ_W'(32768);
  assign term_d   = TERM_W'(sq_rnd_w[SQ_W-1:16]) + TERM_W'(cos_w);

  assign term_o.valid = c_v_q;
  assign term_o.value = term_q;

endmodule

// ===== design/rfa_accum.sv =====
// rfa_accum: saturating fitness accumulator, coordinate and vector counters,
// dimension register and result register. Depends on rfa_pkg, rfa_if.
module rfa_accum
  import rfa_pkg::*;
#(
  parameter int unsigned PopSize = POP_SIZE
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             dimension_we_i,
  input  logic [DIM_W-1:0] dimension_i,
  input  term_t            term_i,
  output logic             adv_o,
  rfa_fit_if.source        fit_if
);

  localparam int unsigned VcW = (PopSize > 1) ? $clog2(PopSize) : 1;

  logic [DIM_W-1:0]   dim_q;
  logic [DIM_W-1:0]   dim_eff_w;
  logic [COUNT_W-1:0] count_q;
  logic [DIM_W-1:0]   count_inc_w;
  logic [VcW-1:0]     vcount_q;
  logic [VcW:0]       vcount_inc_w;
  logic [VcW+4:0]     vcount_ext_w;
  logic [FIT_W-1:0]   psum_q;
  logic [FIT_W:0]     sum_w;
  logic [FIT_W-1:0]   sum_sat_w;
  logic               last_w;
  logic               done_w;
  logic               fit_v_q;
  logic [FIT_W-1:0]   fitness_q;
  logic [IDX_W-1:0]   index_q;

  always_comb begin
    if (dim_q == '0) begin
      dim_eff_w = DIM_W'(1);
    end else if (dim_q > DIM_MAX) begin
      dim_eff_w = DIM_MAX;
    end else begin
      dim_eff_w = dim_q;
    end
  end

  assign count_inc_w  = {1'b0, count_q} + DIM_W'(1);
  assign last_w       = count_inc_w >= dim_eff_w;
  assign sum_w        = {1'b0, psum_q} + {{(FIT_W + 1 - TERM_W){1'b0}}, term_i.value};
  assign sum_sat_w    = sum_w[FIT_W] ? SUM_MAX : sum_w[FIT_W-1:0];
  assign vcount_inc_w = {1'b0, vcount_q} + (VcW + 1)'(1);
  assign vcount_ext_w = {5'b0, vcount_q};

  // hold the pipeline only when a finished vector cannot enter the result register
  assign adv_o  = !(term_i.valid && last_w && fit_v_q && !fit_if.ready);
  assign done_w = adv_o && term_i.valid && last_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q    <= DIM_MAX;
      count_q  <= '0;
      vcount_q <= '0;
      psum_q   <= '0;
      fit_v_q  <= 1'b0;
    end else begin
      if (dimension_we_i) begin
        dim_q <= dimension_i;
      end
      if (adv_o && term_i.valid) begin
        if (last_w) begin
          psum_q  <= '0;
          count_q <= '0;
          if (vcount_inc_w >= (VcW + 1)'(PopSize)) begin
            vcount_q <= '0;
          end else begin
            vcount_q <= vcount_inc_w[VcW-1:0];
          end
        end else begin
          psum_q  <= sum_sat_w;
          count_q <= count_inc_w[COUNT_W-1:0];
        end
      end
      if (done_w) begin
        fit_v_q <= 1'b1;
      end else if (fit_if.ready) begin
        fit_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (done_w) begin
      fitness_q <= sum_sat_w;
      index_q   <= vcount_ext_w[IDX_W-1:0];
    end
  end

  assign fit_if.valid        = fit_v_q;
  assign fit_if.fitness      = fitness_q;
  assign fit_if.vector_index = index_q;

endmodule

// ===== design/rastrigin_fitness_accumulator_core.sv =====
// rastrigin_fitness_accumulator_core: top level, term pipeline plus
// accumulator. Depends on rfa_pkg, rfa_if, rfa_term_pipe, rfa_accum.
//
//   channel     direction  handshake          payload
//   coord_if    in         valid/ready        x_coord (Q11.16, signed)
//   fit_if      out        valid/ready        fitness (Q31.16), vector_index
//   dimension   in         dimension_we_i     dimension_i
//
// one coordinate request per cycle while the pipeline advances; the last
// coordinate of a vector passes three term stages, then the result register
// the term pipeline and accumulator advance together; they hold only while a
// finished vector waits on a full result register
// reset clears counters, sum and valids and sets dimension to 1024
module rastrigin_fitness_accumulator_core
  import rfa_pkg::*;
#(
  parameter int unsigned PopSize       = POP_SIZE,
  parameter int unsigned CosTableDepth = COS_TABLE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             dimension_we_i,
  input  logic [DIM_W-1:0] dimension_i,
  rfa_coord_if.sink        coord_if,
  rfa_fit_if.source        fit_if
);

  logic  adv_w;
  term_t term_w;

  rfa_term_pipe #(
    .CosTableDepth(CosTableDepth)
  ) u_term_pipe (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv_w),
    .coord_if(coord_if),
    .term_o  (term_w)
  );

  rfa_accum #(
    .PopSize(PopSize)
  ) u_accum (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .dimension_we_i(dimension_we_i),
    .dimension_i   (dimension_i),
    .term_i        (term_w),
    .adv_o         (adv_w),
    .fit_if        (fit_if)
  );

endmodule
